// File: design/fixed_partition_fit_allocator_core_macros.svh
// Assertion helpers used by the allocator core
`ifndef FIXED_PARTITION_FIT_ALLOCATOR_CORE_MACROS_SVH
`define FIXED_PARTITION_FIT_ALLOCATOR_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset
`define FPFA_CHK_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("allocator check failed");

// Next-cycle implication, checked out of reset
`define FPFA_CHK_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("allocator check failed");

`endif

// File: design/fpfa_pkg.sv
package fpfa_pkg;

   // Storage dimensions
   localparam int MAX_BLOCKS = 16;
   localparam int SIZE_BITS  = 16;
   localparam int IDX_BITS   = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

   // Fixed port widths
   localparam int FUNC_BITS      = 2;
   localparam int PORT_IDX_BITS  = 4;
   localparam int PORT_SIZE_BITS = 16;
   localparam int POLICY_BITS    = 2;
   localparam int COUNT_BITS     = 5;
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 5;
   // common width for comparing a scan index with the partition count
   localparam int CMP_BITS       = IDX_BITS + COUNT_BITS;

   // Item function codes
   localparam logic [FUNC_BITS-1:0] FUNC_LOAD  = 2'd0;
   localparam logic [FUNC_BITS-1:0] FUNC_CLEAR = 2'd1;
   localparam logic [FUNC_BITS-1:0] FUNC_PLACE = 2'd2;

   // Placement policies
   localparam logic [POLICY_BITS-1:0] POLICY_FIRST = 2'd0;
   localparam logic [POLICY_BITS-1:0] POLICY_BEST  = 2'd1;
   localparam logic [POLICY_BITS-1:0] POLICY_WORST = 2'd2;

   // Register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_POLICY      = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BLOCK_COUNT = 1'd1;

   // Controller to datapath commands
   typedef struct packed {
      logic write_size;
      logic clear_marks;
      logic start;
      logic step;
      logic commit;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic scan_end;
      logic out_free;
   } status_type;

   // Port-width size to internal size: keep the low SIZE_BITS bits
   function automatic logic [SIZE_BITS-1:0] to_size(input logic [PORT_SIZE_BITS-1:0] v);
      logic [31:0] w;
      w = 32'(v);
      return w[SIZE_BITS-1:0];
   endfunction

   // Internal size to port width
   function automatic logic [PORT_SIZE_BITS-1:0] to_port_size(input logic [SIZE_BITS-1:0] v);
      logic [31:0] w;
      w = 32'(v);
      return w[PORT_SIZE_BITS-1:0];
   endfunction

endpackage

// File: design/fpfa_datapath.sv
module fpfa_datapath
   import fpfa_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  cmd_type                   cmd,
   output status_type                status,
   input  logic                      csr_valid,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   input  logic [PORT_IDX_BITS-1:0]  req_block_index,
   input  logic [PORT_SIZE_BITS-1:0] req_block_size,
   input  logic [PORT_SIZE_BITS-1:0] req_request_size,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_granted,
   output logic [PORT_IDX_BITS-1:0]  rsp_granted_index,
   output logic [PORT_SIZE_BITS-1:0] rsp_granted_block_size
);

   logic [SIZE_BITS-1:0]      sizes_ff [MAX_BLOCKS];
   logic [MAX_BLOCKS-1:0]     used_ff;
   logic [POLICY_BITS-1:0]    policy_ff;
   logic [COUNT_BITS-1:0]     count_ff;
   logic [SIZE_BITS-1:0]      request_ff;
   logic [IDX_BITS-1:0]       idx_ff;
   logic                      found_ff;
   logic [IDX_BITS-1:0]       pick_ff;
   logic [SIZE_BITS-1:0]      pick_size_ff;
   logic                      rsp_valid_ff;
   logic                      rsp_granted_ff;
   logic [PORT_IDX_BITS-1:0]  rsp_index_ff;
   logic [PORT_SIZE_BITS-1:0] rsp_size_ff;

   logic [31:0]               load_wide;
   logic                      load_ok;
   logic [IDX_BITS-1:0]       load_idx;
   logic [SIZE_BITS-1:0]      cur_size;
   logic                      candidate;
   logic                      take;
   logic [31:0]               pick_wide;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff <= POLICY_FIRST;
         count_ff  <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_POLICY:      policy_ff <= csr_wdata[POLICY_BITS-1:0];
            CSR_BLOCK_COUNT: count_ff  <= csr_wdata[COUNT_BITS-1:0];
            default:         ;
         endcase
      end
   end

   // Partition size table; loads past the table are dropped
   assign load_wide = 32'(req_block_index);
   assign load_ok   = load_wide < 32'(MAX_BLOCKS);
   assign load_idx  = load_wide[IDX_BITS-1:0];

   always_ff @(posedge clock) begin
      if (cmd.write_size && load_ok) begin
         sizes_ff[load_idx] <= to_size(req_block_size);
      end
   end

   // Candidate test for the partition under the scan pointer
   assign cur_size  = sizes_ff[idx_ff];
   assign candidate = !used_ff[idx_ff] && (cur_size >= request_ff)
                      && (CMP_BITS'(idx_ff) < CMP_BITS'(count_ff))
                      && (policy_ff == POLICY_FIRST || policy_ff == POLICY_BEST
                          || policy_ff == POLICY_WORST);
   assign take      = candidate && (!found_ff
                      || (policy_ff == POLICY_BEST  && cur_size < pick_size_ff)
                      || (policy_ff == POLICY_WORST && cur_size > pick_size_ff));

   // Scan state: pointer, best pick so far
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         request_ff   <= to_size(req_request_size);
         idx_ff       <= '0;
         found_ff     <= 1'b0;
         pick_ff      <= '0;
         pick_size_ff <= '0;
      end else if (cmd.step) begin
         idx_ff <= idx_ff + 1'b1;
         if (take) begin
            found_ff     <= 1'b1;
            pick_ff      <= idx_ff;
            pick_size_ff <= cur_size;
         end
      end
   end

   // Used marks
   always_ff @(posedge clock) begin
      if (reset || cmd.clear_marks) begin
         used_ff <= '0;
      end else if (cmd.commit && found_ff) begin
         used_ff[pick_ff] <= 1'b1;
      end
   end

   // Result register
   assign pick_wide = 32'(pick_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_granted_ff <= found_ff;
         rsp_index_ff   <= found_ff ? pick_wide[PORT_IDX_BITS-1:0] : '0;
         rsp_size_ff    <= found_ff ? to_port_size(pick_size_ff) : '0;
      end
   end

   assign status.scan_end = (idx_ff == IDX_BITS'(MAX_BLOCKS - 1));
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_granted            = rsp_granted_ff;
   assign rsp_granted_index      = rsp_index_ff;
   assign rsp_granted_block_size = rsp_size_ff;

endmodule

// File: design/fpfa_ctrl.sv
module fpfa_ctrl
   import fpfa_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [FUNC_BITS-1:0] req_func,
   input  status_type           status,
   output cmd_type              cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   state_type state_ff;
   logic      accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   // Command decode
   always_comb begin
      cmd             = '0;
      cmd.write_size  = accept && (req_func == FUNC_LOAD);
      cmd.clear_marks = accept && (req_func == FUNC_CLEAR);
      cmd.start       = accept && (req_func == FUNC_PLACE);
      cmd.step        = (state_ff == ST_SCAN);
      cmd.commit      = (state_ff == ST_FINISH) && status.out_free;
   end

   // Sequencer: scan every partition, then wait for room in the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (accept && req_func == FUNC_PLACE) state_ff <= ST_SCAN;
            end
            ST_SCAN: begin
               if (status.scan_end) state_ff <= ST_FINISH;
            end
            ST_FINISH: begin
               if (status.out_free) state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

// File: design/fixed_partition_fit_allocator_core.sv
// Fixed-partition allocator with first, best and worst fit placement.
// Request channel (req_valid / req_stall): func 0 loads block_size into
// partition block_index, func 1 clears all used marks, func 2 places a
// request of request_size; code 3 is dropped. Loads and clears give no
// response.
// A placement walks all 16 partitions one per cycle through a single
// compare unit, then commits the pick in its finish state. No request
// is taken while a placement is in progress; the next item is taken
// the cycle after the commit.
// Response channel (rsp_valid / rsp_stall): one transfer per placement
// with granted, granted_index and granted_block_size (zeros if none fit).
// The response sits in an output register; while it stalls, a following
// placement scans and then holds in its commit cycle until room frees up.
// Config port (csr_valid / csr_ready, always ready): index 0 policy,
// index 1 block_count. Write only while the block is idle.
// Reset clears used marks, policy and block_count and empties the output;
// partition sizes are undefined until loaded.
module fixed_partition_fit_allocator_core
   import fpfa_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [FUNC_BITS-1:0]      req_func,
   input  logic [PORT_IDX_BITS-1:0]  req_block_index,
   input  logic [PORT_SIZE_BITS-1:0] req_block_size,
   input  logic [PORT_SIZE_BITS-1:0] req_request_size,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_granted,
   output logic [PORT_IDX_BITS-1:0]  rsp_granted_index,
   output logic [PORT_SIZE_BITS-1:0] rsp_granted_block_size,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

`include "fixed_partition_fit_allocator_core_macros.svh"

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   fpfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_func  (req_func),
      .status    (status),
      .cmd       (cmd)
   );

   fpfa_datapath u_datapath (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .status                 (status),
      .csr_valid              (csr_valid && csr_ready),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata),
      .req_block_index        (req_block_index),
      .req_block_size         (req_block_size),
      .req_request_size       (req_request_size),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_granted            (rsp_granted),
      .rsp_granted_index      (rsp_granted_index),
      .rsp_granted_block_size (rsp_granted_block_size)
   );

   // A refused placement reports zeros
   `FPFA_CHK_SAME(a_deny_zero, clock, reset, rsp_valid && !rsp_granted,
      rsp_granted_index == '0 && rsp_granted_block_size == '0)
   // A placement blocks further requests while it scans
   `FPFA_CHK_NEXT(a_place_busy, clock, reset,
      req_valid && !req_stall && req_func == FUNC_PLACE, req_stall)
   // A commit always presents a response
   `FPFA_CHK_NEXT(a_commit_out, clock, reset, cmd.commit, rsp_valid)
   // Commits only happen while requests are blocked
   `FPFA_CHK_SAME(a_commit_busy, clock, reset, cmd.commit, req_stall)

endmodule
